@@ hdl/afsa_pkg.sv @@
// ----------------------------------------------------------------------------
// afsa_pkg
// shared types and constants for the fresh sample averager
// ----------------------------------------------------------------------------
package afsa_pkg;

	localparam int CHANNELS_DEF    = 8;
	localparam int MAX_SAMPLES_DEF = 256;

	// field widths fixed by the beat format
	localparam int CH_FIELD_W = 3;
	localparam int SMP_W      = 16;
	localparam int AVG_W      = 15;
	localparam int STALE_BIT  = 15;

	// command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef struct packed {
		logic                  command;
		logic [CH_FIELD_W-1:0] channel;
		logic [SMP_W-1:0]      sample;
	} afsa_in_t;

	typedef struct packed {
		logic [CH_FIELD_W-1:0] out_channel;
		logic [AVG_W-1:0]      average;
		logic                  last;
	} afsa_out_t;

endpackage

@@ hdl/afsa_store.sv @@
// ----------------------------------------------------------------------------
// afsa_store
// per-channel sum and count registers with saturating accumulate and clear
// ----------------------------------------------------------------------------
module afsa_store
	import afsa_pkg::*;
#(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
	localparam int SUM_W = AVG_W + $clog2(MAX_SAMPLES),
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc_en,
	input  logic [IDX_W-1:0] acc_idx,
	input  logic [AVG_W-1:0] acc_val,
	input  logic             clr_en,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [SUM_W-1:0] rd_sum,
	output logic [CNT_W-1:0] rd_cnt
);

	logic [SUM_W-1:0] sums_q [CHANNELS];
	logic [CNT_W-1:0] cnts_q [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sums_q[i] <= '0;
				cnts_q[i] <= '0;
			end
		end else begin
			// window full: further samples dropped until the next clear
			if (acc_en && (cnts_q[acc_idx] < CNT_W'(MAX_SAMPLES))) begin
				sums_q[acc_idx] <= sums_q[acc_idx] + SUM_W'(acc_val);
				cnts_q[acc_idx] <= cnts_q[acc_idx] + CNT_W'(1);
			end
			if (clr_en) begin
				sums_q[rd_idx] <= '0;
				cnts_q[rd_idx] <= '0;
			end
		end
	end

	assign rd_sum = sums_q[rd_idx];
	assign rd_cnt = cnts_q[rd_idx];

endmodule

@@ hdl/afsa_div.sv @@
// ----------------------------------------------------------------------------
// afsa_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module afsa_div
	import afsa_pkg::*;
#(
	parameter int SUM_W = AVG_W + 8,
	parameter int CNT_W = 9,
	localparam int STEP_W = $clog2(SUM_W + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [AVG_W-1:0] quotient
);

	logic [CNT_W:0]    rem_q;
	logic [SUM_W-1:0]  num_q;
	logic [CNT_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0]   rem_shift;
	logic [CNT_W+1:0] trial;
	logic             ge;

	assign rem_shift = {rem_q[CNT_W-1:0], num_q[SUM_W-1]};
	assign trial     = {1'b0, rem_shift} - {2'b00, den_q};
	assign ge        = !trial[CNT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[CNT_W:0] : rem_shift;
			num_q <= {num_q[SUM_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = num_q[AVG_W-1:0];

`ifndef SYNTH
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q))
		else $error("divider done without a running division");
`endif

endmodule

@@ hdl/adc_fresh_sample_averager_core.sv @@
// ----------------------------------------------------------------------------
// adc_fresh_sample_averager_core
// windowed per-channel averaging of tagged converter samples
// ----------------------------------------------------------------------------
// usage:
//  - input channel (in_valid/in_ready/in_data) takes one beat per cycle while
//    idle; a sample beat (command 0) adds a fresh sample (bit 15 clear) to its
//    channel's sum and count, and a beat for a channel past CHANNELS, a stale
//    sample or a sample for a full window (MAX_SAMPLES) changes nothing
//  - a tick beat (command 1) makes the block emit CHANNELS result beats on
//    out_valid/out_ready/out_data, channel 0 first, last set on the final one
//  - each result is sum / count truncated, or 0 for a channel with no sample;
//    the channel's sum and count are cleared as it is read out
//  - no result follows a sample beat
//  - a tick walks each channel in turn through a load state, SUM_W divider
//    steps with SUM_W = 15 + log2 of MAX_SAMPLES, and an output state; an
//    empty channel skips the divider;
//    in_ready stays low from the tick until the last result is registered
//  - a stalled receiver holds the output register; the sequencer waits
//  - reset clears all sums, counts, the sequencer and out_valid
// ----------------------------------------------------------------------------
module adc_fresh_sample_averager_core
	import afsa_pkg::*;
#(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  afsa_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output afsa_out_t out_data
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SUM_W = AVG_W + $clog2(MAX_SAMPLES);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOAD = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} afsa_state_t;

	afsa_state_t state_q;
	logic [IDX_W-1:0] idx_q;
	logic [AVG_W-1:0] res_q;
	logic             out_valid_q;
	afsa_out_t        out_data_q;

	logic             in_beat;
	logic             ch_ok;
	logic             acc_en;
	logic [SUM_W-1:0] rd_sum;
	logic [CNT_W-1:0] rd_cnt;
	logic             div_start;
	logic             div_busy;
	logic             div_done;
	logic [AVG_W-1:0] div_quo;
	logic             out_free;
	logic             idx_last;

	assign in_ready = (state_q == S_IDLE);
	assign in_beat  = in_valid && in_ready;

	// channel tags beyond the configured count are dropped
	assign ch_ok  = (32'(in_data.channel) < CHANNELS);
	assign acc_en = in_beat && (in_data.command == CMD_SAMPLE) && ch_ok
		&& !in_data.sample[STALE_BIT];

	// empty channel skips the divider and reports zero
	assign div_start = (state_q == S_LOAD) && (rd_cnt != '0);
	assign out_free  = !out_valid_q || out_ready;
	assign idx_last  = (idx_q == IDX_W'(CHANNELS - 1));

	afsa_store #(
		.CHANNELS    (CHANNELS),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc_en  (acc_en),
		.acc_idx (in_data.channel[IDX_W-1:0]),
		.acc_val (in_data.sample[AVG_W-1:0]),
		.clr_en  (state_q == S_LOAD),
		.rd_idx  (idx_q),
		.rd_sum  (rd_sum),
		.rd_cnt  (rd_cnt)
	);

	afsa_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_sum),
		.divisor  (rd_cnt),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequencer: load channel, divide, hand result to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_beat && (in_data.command == CMD_TICK)) begin
						state_q <= S_LOAD;
						idx_q   <= '0;
					end
				end
				S_LOAD: begin
					state_q <= (rd_cnt != '0) ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (idx_last) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_LOAD;
							idx_q   <= idx_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result holding register between divider and output
	always_ff @(posedge clk) begin
		if ((state_q == S_LOAD) && (rd_cnt == '0)) begin
			res_q <= '0;
		end else if ((state_q == S_DIV) && div_done) begin
			res_q <= div_quo;
		end
	end

	// output register: holds the beat while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			out_data_q.out_channel <= CH_FIELD_W'(idx_q);
			out_data_q.average     <= res_q;
			out_data_q.last        <= idx_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	a_tick_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && (in_data.command == CMD_TICK)) |=> !in_ready)
		else $error("input accepted right after a tick");

	a_last_is_top_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.last) |->
		(out_data.out_channel == CH_FIELD_W'(CHANNELS - 1)))
		else $error("last flag on a channel other than the final one");

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == S_DIV))
		else $error("divider running outside the divide state");
`endif

endmodule
